[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

[hw/rtl/smfb_pkg.sv]
package smfb_pkg;
    localparam logic [14:0] LOG2E_Q14 = 15'd23637;

    // 2^(-k/16) in Q.16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        case (k)
            5'd0:  pow2_neg = 17'd65536;
            5'd1:  pow2_neg = 17'd62757;
            5'd2:  pow2_neg = 17'd60097;
            5'd3:  pow2_neg = 17'd57549;
            5'd4:  pow2_neg = 17'd55109;
            5'd5:  pow2_neg = 17'd52773;
            5'd6:  pow2_neg = 17'd50535;
            5'd7:  pow2_neg = 17'd48393;
            5'd8:  pow2_neg = 17'd46341;
            5'd9:  pow2_neg = 17'd44376;
            5'd10: pow2_neg = 17'd42495;
            5'd11: pow2_neg = 17'd40693;
            5'd12: pow2_neg = 17'd38968;
            5'd13: pow2_neg = 17'd37316;
            5'd14: pow2_neg = 17'd35734;
            5'd15: pow2_neg = 17'd34219;
            default: pow2_neg = 17'd32768;
        endcase
    endfunction
endpackage

[hw/rtl/smfb_exp.sv]
// Two-stage exp(-a) for a in Q.10, result Q.16 in [0, 65536]
module smfb_exp (
    input  logic        aclk,
    input  logic [15:0] a,
    output logic [16:0] e
);
    logic [31:0] prod;
    logic [23:0] u_reg;
    logic [7:0]  n;
    logic [3:0]  k;
    logic [11:0] r;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [28:0] slope;
    logic [16:0] v;

    // scale by log2(e)
    assign prod = {16'd0, a} * {17'd0, smfb_pkg::LOG2E_Q14} + 32'd128;
    always_ff @(posedge aclk) begin
        u_reg <= prod[31:8];
    end

    // interpolate the fraction, shift by the integer part
    assign n     = u_reg[23:16];
    assign k     = u_reg[15:12];
    assign r     = u_reg[11:0];
    assign t0    = smfb_pkg::pow2_neg({1'b0, k});
    assign t1    = smfb_pkg::pow2_neg({1'b0, k} + 5'd1);
    assign slope = {12'd0, t0 - t1} * {17'd0, r} + 29'd2048;
    assign v     = t0 - slope[28:12];
    always_ff @(posedge aclk) begin
        e <= (n < 8'd17) ? (v >> n[4:0]) : 17'd0;
    end
endmodule

[hw/rtl/smfb_div.sv]
// Restoring divider: q = (e*65536 + s/2) / s, capped at 65535 (0 if s is 0), one quotient bit per cycle
module smfb_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] e,
    input  logic [31:0] s,
    output logic        done,
    output logic [15:0] q
);
    logic [33:0] num_reg, num_next;
    logic [33:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg[31:0], num_reg[33]};

    always_comb begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            num_next  = {1'b0, e, 16'd0} + {3'd0, s[31:1]};
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = 6'd34;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[32:0], 1'b0};
            if (trial >= {1'b0, s}) begin
                rem_next = trial - {1'b0, s};
                quo_next = {quo_reg[32:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= busy_reg && (cnt_reg == 6'd1);
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign q = (s == 32'd0) ? 16'd0 :
               (quo_reg[33:16] != 18'd0) ? 16'hFFFF : quo_reg[15:0];
    assign done = done_reg;
endmodule

[hw/rtl/softmax_forward_backward_top.sv]
// Channel | Dir | Fields (tdata low bit up)
// s_axis  | in  | logit[15:0], upstream_grad[31:16]; tlast = last
// m_axis  | out | probability[15:0], gradient[31:16], too_long[32]; tlast
// cfg     | in  | mode (cfg_we, cfg_wdata)
// Loading takes one cycle an item. At close three passes over the n stored
// elements follow: exp sum, dot sum (exp plus a bit-serial divide), then a
// step to fix the dot product, and last the emit pass.
// Reset is synchronous; no new item is taken until the last result leaves.
// m_axis stalls hold the emit pass.
`include "assert_macros.svh"
module softmax_forward_backward_top #(
    parameter int MAX_LENGTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // logit, upstream_grad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // probability, gradient, too_long, zeros
    output logic        m_axis_tlast
);
    localparam int AW = $clog2(MAX_LENGTH);
    localparam int CW = $clog2(MAX_LENGTH + 1);

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EXP  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_GRAD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [1:0] P_SUM = 2'd0;
    localparam logic [1:0] P_DOT = 2'd1;
    localparam logic [1:0] P_EMIT = 2'd2;

    logic [31:0] mem [MAX_LENGTH];
    logic [31:0] rd_reg;

    logic [2:0]    st_reg;
    logic [1:0]    pass_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] idx_reg;
    logic [2:0]    wait_reg;
    logic          mode_reg;
    logic          mode_lat_reg;
    logic          ovf_reg;
    logic signed [15:0] max_reg;
    logic [31:0]   sum_reg;
    logic signed [39:0] dot_reg;
    logic signed [16:0] dotq_reg;
    logic [15:0]   y_reg;
    logic signed [15:0] g_reg;
    logic          out_last_reg;

    logic signed [15:0] in_logit;
    logic          acc;
    logic          full;
    logic [AW-1:0] last_idx;
    logic signed [16:0] diff;
    logic [15:0]   exp_a;
    logic [16:0]   exp_e;
    logic          div_start;
    logic          div_done;
    logic [15:0]   div_q;
    logic signed [15:0] gu;
    logic signed [39:0] dot_add;
    logic signed [39:0] dot_rnd;
    logic signed [17:0] gdiff;
    logic signed [34:0] gprod;
    logic signed [34:0] grnd;

    assign in_logit = s_axis_tdata[15:0];
    assign s_axis_tready = (st_reg == ST_LOAD);
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign full = (cnt_reg == CW'(MAX_LENGTH));
    assign last_idx = AW'(cnt_reg - CW'(1));

    // exp unit input from the stored logit
    assign diff  = {max_reg[15], max_reg} - {rd_reg[15], rd_reg[15:0]};
    assign exp_a = diff[16] ? 16'd0 : diff[15:0];

    smfb_exp u_exp (.aclk(aclk), .a(exp_a), .e(exp_e));

    assign div_start = (st_reg == ST_EXP) && (wait_reg == 3'd2) && (pass_reg != P_SUM);
    smfb_div u_div (.aclk(aclk), .aresetn(aresetn), .start(div_start), .e(exp_e),
                    .s(sum_reg), .done(div_done), .q(div_q));

    assign gu      = rd_reg[31:16];
    assign dot_add = 40'(gu) * 40'($signed({1'b0, div_q}));
    // round dot to Q.12, ties away from zero
    assign dot_rnd = dot_reg[39] ? -((-dot_reg + 40'sd32768) >>> 16)
                                 : ((dot_reg + 40'sd32768) >>> 16);
    assign gdiff = 18'(gu) - 18'(dotq_reg);
    assign gprod = $signed({1'b0, y_reg}) * gdiff;
    assign grnd  = gprod[34] ? -((-gprod + 35'sd32768) >>> 16)
                             : ((gprod + 35'sd32768) >>> 16);

    // store and read the vector memory
    always_ff @(posedge aclk) begin
        if (acc && !full) begin
            mem[cnt_reg[AW-1:0]] <= s_axis_tdata;
        end
        rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_LOAD;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            max_reg  <= 16'sh8000;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            unique case (st_reg)
                ST_LOAD: begin
                    if (acc) begin
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            cnt_reg <= cnt_reg + CW'(1);
                            if (in_logit > max_reg) max_reg <= in_logit;
                        end
                        if (s_axis_tlast) begin
                            mode_lat_reg <= mode_reg;
                            pass_reg <= P_SUM;
                            idx_reg  <= '0;
                            sum_reg  <= '0;
                            dot_reg  <= '0;
                            wait_reg <= '0;
                            st_reg   <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    st_reg <= ST_EXP;
                    wait_reg <= '0;
                end
                ST_EXP: begin
                    // rd_reg valid now; exp result follows through u_reg and e of the exp unit
                    wait_reg <= wait_reg + 3'd1;
                    if (wait_reg == 3'd2) begin
                        if (pass_reg == P_SUM) begin
                            sum_reg <= sum_reg + {15'd0, exp_e};
                            if (idx_reg == last_idx) begin
                                pass_reg <= P_DOT;
                                idx_reg  <= '0;
                            end else begin
                                idx_reg <= idx_reg + AW'(1);
                            end
                            st_reg <= ST_RD;
                        end else begin
                            st_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (pass_reg == P_DOT) begin
                            dot_reg <= dot_reg + dot_add;
                            if (idx_reg == last_idx) begin
                                pass_reg <= P_EMIT;
                                idx_reg  <= '0;
                                st_reg   <= ST_GRAD;
                            end else begin
                                idx_reg <= idx_reg + AW'(1);
                                st_reg  <= ST_RD;
                            end
                        end else begin
                            // mark the emit-pass entry into GRAD
                            y_reg    <= div_q;
                            wait_reg <= 3'd7;
                            st_reg   <= ST_GRAD;
                        end
                    end
                end
                ST_GRAD: begin
                    if (pass_reg == P_EMIT && wait_reg != 3'd7) begin
                        // first entry from the dot pass: fix dot, restart reads
                        dotq_reg <= 17'(dot_rnd);
                        wait_reg <= 3'd7;
                        st_reg   <= ST_RD;
                    end else begin
                        if (!mode_lat_reg) g_reg <= '0;
                        else if (grnd > 35'sd32767) g_reg <= 16'sh7FFF;
                        else if (grnd < -35'sd32768) g_reg <= 16'sh8000;
                        else g_reg <= 16'(grnd);
                        out_last_reg  <= (idx_reg == last_idx);
                        m_axis_tvalid <= 1'b1;
                        st_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        if (out_last_reg) begin
                            st_reg  <= ST_LOAD;
                            cnt_reg <= '0;
                            ovf_reg <= 1'b0;
                            max_reg <= 16'sh8000;
                        end else begin
                            idx_reg <= idx_reg + AW'(1);
                            st_reg  <= ST_RD;
                            wait_reg <= 3'd7;
                        end
                    end
                end
                default: st_reg <= ST_LOAD;
            endcase
        end
    end

    // pack the result item
    assign m_axis_tdata = {7'd0, ovf_reg, g_reg, y_reg};
    assign m_axis_tlast = out_last_reg;

    `ASSERT_NEVER(a_no_in_while_busy, aclk, aresetn, acc && st_reg != ST_LOAD,
                  "item taken outside load")
    `ASSERT_IMPL(a_out_hold, aclk, aresetn,
                 m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
                 "result changed while stalled")
    `ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > CW'(MAX_LENGTH),
                  "element count beyond maximum")
endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VEC_MAX     = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 350;

    localparam bit MODE_FORWARD  = 1'b0;
    localparam bit MODE_BACKWARD = 1'b1;

    // 2^(-k/16) in Q.16, k = 0..16
    localparam int unsigned POW2_FRAC [17] = '{
        65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
        44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
    };

    typedef struct packed {
        logic [15:0] prob;
        logic [15:0] grad;
        logic        too_long;
        logic        eov;
    } softmax_result_t;

    typedef struct {
        bit                 md;
        logic signed [15:0] logit;
        logic signed [15:0] ugrad;
        bit                 last;
        bit                 typed;
        logic [15:0]        t_prob;
        logic [15:0]        t_grad;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // logit, upstream_grad
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // probability, gradient, too_long, zeros
    logic        m_axis_tlast;

    softmax_result_t    pending_results[$];
    logic signed [15:0] vec_logits[$];
    logic signed [15:0] vec_grads[$];
    bit                 vec_dropped = 1'b0;
    bit                 cur_mode = MODE_FORWARD;
    bit                 failed = 1'b0;
    bit                 tx_fast = 1'b0;
    bit                 rx_fast = 1'b0;
    bit                 hold_req = 1'b0;
    bit                 hold_done = 1'b0;
    int                 results_seen = 0;
    int                 cycles = 0;

    softmax_forward_backward_top #(.MAX_LENGTH(VEC_MAX)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 aclk = ~aclk;

    // exp(-a) for a in Q.10, result in Q.16
    function automatic int unsigned exp_neg_q16(int unsigned a);
        longint unsigned u, n, f, k, r, v;
        u = (longint'(a) * 23637 + 128) >> 8;
        n = u >> 16;
        f = u & 16'hFFFF;
        k = f >> 12;
        r = f & 12'hFFF;
        v = POW2_FRAC[k] - (((POW2_FRAC[k] - POW2_FRAC[k+1]) * r + 2048) >> 12);
        return (n < 17) ? 32'(v >> n) : 32'd0;
    endfunction

    // Round to nearest, ties away from zero, after dropping 16 bits
    function automatic longint round_q16(longint v);
        if (v >= 0)
            return (v + 32768) >>> 16;
        return -((-v + 32768) >>> 16);
    endfunction

    // Work out every result of the closed vector
    task automatic predict_softmax();
        int              n;
        int              mx;
        int unsigned     ex[$];
        longint unsigned esum;
        longint          y[$];
        longint          dsum, dot, g;
        softmax_result_t r;
        n = vec_logits.size();
        mx = -32768;
        esum = 0;
        dsum = 0;
        foreach (vec_logits[i])
            if (int'(vec_logits[i]) > mx) mx = vec_logits[i];
        foreach (vec_logits[i]) begin
            ex.push_back(exp_neg_q16(mx - int'(vec_logits[i])));
            esum += ex[i];
        end
        foreach (ex[i]) begin
            y.push_back(((longint'(ex[i]) << 16) + (esum >> 1)) / esum);
            if (y[i] > 65535) y[i] = 65535;
            dsum += longint'(vec_grads[i]) * y[i];
        end
        dot = round_q16(dsum);
        for (int i = 0; i < n; i++) begin
            g = 0;
            if (cur_mode == MODE_BACKWARD) begin
                g = round_q16(y[i] * (longint'(vec_grads[i]) - dot));
                if (g > 32767) g = 32767;
                if (g < -32768) g = -32768;
            end
            r.prob = y[i][15:0];
            r.grad = g[15:0];
            r.too_long = vec_dropped;
            r.eov = (i == n - 1);
            pending_results.push_back(r);
        end
    endtask

    // Hold until the block is idle, then write the mode register
    task automatic write_mode(bit md);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = md;
        @(negedge aclk);
        cfg_we = 1'b0;
        cur_mode = md;
    endtask

    // Offer one item and track it once accepted
    task automatic send_item(logic signed [15:0] lg, logic signed [15:0] gu, bit last,
                             bit typed, logic [15:0] t_prob, logic [15:0] t_grad);
        int gap;
        softmax_result_t r;
        gap = tx_fast ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {gu, lg};
        s_axis_tlast = last;
        do @(posedge aclk); while (!s_axis_tready);
        if (vec_logits.size() < VEC_MAX) begin
            vec_logits.push_back(lg);
            vec_grads.push_back(gu);
        end else begin
            vec_dropped = 1'b1;
        end
        if (last) begin
            if (typed) begin
                r.prob = t_prob;
                r.grad = t_grad;
                r.too_long = 1'b0;
                r.eov = 1'b1;
                pending_results.push_back(r);
            end else begin
                predict_softmax();
            end
            vec_logits.delete();
            vec_grads.delete();
            vec_dropped = 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    stim_row_t stim_rows [15] = '{
        '{MODE_FORWARD,  16'sd32767,  16'sd0,      1, 1, 16'd65535, 16'd0},
        '{MODE_FORWARD,  -16'sd32768, -16'sd32768, 1, 1, 16'd65535, 16'd0},
        '{MODE_BACKWARD, -16'sd32768, 16'sd32767,  0, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, 16'sd32767,  -16'sd32768, 1, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, 16'sd0,      16'sd32767,  1, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, 16'sd1024,   16'sd4096,   0, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, 16'sd1024,   -16'sd4096,  0, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, 16'sd1024,   16'sd0,      1, 0, 16'd0, 16'd0},
        '{MODE_FORWARD,  -16'sd5000,  16'sd100,    0, 0, 16'd0, 16'd0},
        '{MODE_FORWARD,  16'sd3000,   16'sd200,    0, 0, 16'd0, 16'd0},
        '{MODE_FORWARD,  16'sd0,      -16'sd300,   1, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, -16'sd2048,  16'sd32767,  0, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, -16'sd1024,  -16'sd32768, 0, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, 16'sd0,      16'sd32767,  1, 0, 16'd0, 16'd0},
        '{MODE_BACKWARD, 16'sd100,    -16'sd32768, 1, 0, 16'd0, 16'd0}
    };

    // Stimulus: directed rows, then random vectors
    initial begin
        int sent, len, base, lv, gv;
        bit narrow, wide_grad;
        sent = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        for (int i = 0; i < $size(stim_rows); i++) begin
            if (i == 0 || stim_rows[i-1].last)
                write_mode(stim_rows[i].md);
            send_item(stim_rows[i].logit, stim_rows[i].ugrad, stim_rows[i].last,
                      stim_rows[i].typed, stim_rows[i].t_prob, stim_rows[i].t_grad);
        end
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19)) inside
                [0:13]:  len = $urandom_range(1, 8);
                [14:17]: len = $urandom_range(9, VEC_MAX);
                default: len = $urandom_range(VEC_MAX + 1, VEC_MAX + 6);
            endcase
            if ($urandom_range(0, 2) == 0)
                write_mode($urandom_range(0, 1));
            tx_fast = ($urandom_range(0, 3) == 0);
            narrow = $urandom_range(0, 1);
            wide_grad = ($urandom_range(0, 3) != 0);
            base = $urandom_range(0, 65535) - 32768;
            for (int j = 0; j < len; j++) begin
                if (narrow) begin
                    lv = base + $urandom_range(0, 8191) - 4096;
                    if (lv > 32767) lv = 32767;
                    if (lv < -32768) lv = -32768;
                end else begin
                    lv = $urandom_range(0, 65535) - 32768;
                end
                gv = wide_grad ? $urandom_range(0, 65535) - 32768
                               : $urandom_range(0, 8191) - 4096;
                send_item(lv[15:0], gv[15:0], j == len - 1, 1'b0, 16'd0, 16'd0);
            end
            sent += len;
        end
        // Drain, then allow the block to settle
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (!failed)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side ready, with random waits and one long hold-off
    initial begin
        int w;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (400) @(negedge aclk);
            end
            w = rx_fast ? 0 : $urandom_range(0, 9);
            if (w != 0) begin
                m_axis_tready = 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && aresetn));
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        softmax_result_t e;
        cycles <= cycles + 1;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            // hold off once while the sender is offering an item
            if (!hold_done && results_seen >= 30 && s_axis_tvalid) begin
                hold_req  <= 1'b1;
                hold_done <= 1'b1;
            end
            if (results_seen % 50 == 0) rx_fast <= ($urandom_range(0, 3) == 0);
            if (pending_results.size() == 0) begin
                $error("unexpected result item: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                failed <= 1'b1;
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== e.prob) begin
                    $error("probability: expected %0d, got %0d", e.prob, m_axis_tdata[15:0]);
                    failed <= 1'b1;
                end
                if (m_axis_tdata[31:16] !== e.grad) begin
                    $error("gradient: expected %0d, got %0d",
                           $signed(e.grad), $signed(m_axis_tdata[31:16]));
                    failed <= 1'b1;
                end
                if (m_axis_tdata[32] !== e.too_long) begin
                    $error("too_long: expected %0b, got %0b", e.too_long, m_axis_tdata[32]);
                    failed <= 1'b1;
                end
                if (m_axis_tlast !== e.eov) begin
                    $error("end_of_vector: expected %0b, got %0b", e.eov, m_axis_tlast);
                    failed <= 1'b1;
                end
            end
        end
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/smfb_pkg.sv
hw/rtl/smfb_exp.sv
hw/rtl/smfb_div.sv
hw/rtl/softmax_forward_backward_top.sv
tb/sv/tb_top.sv
